// ----- sv/swg_pkg.sv -----
// Shared types and constants of the 3x3 sliding window generator.
// No dependencies; imported by swg_front, swg_back and the top level.
package swg_pkg;

    localparam int KERNEL_SIZE   = 3;
    localparam int PIXEL_BITS    = 24;
    localparam int CFG_BITS      = 12;
    localparam int IDX_BITS      = 2;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MID_DEPTH     = 2;
    localparam int OUT_DEPTH     = 4;

    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_PAD_PIXEL    = 2'd2;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef struct packed {
        pixel_t pixel_in;
        logic   is_drain;
    } in_item_t;

    typedef struct packed {
        pixel_t win_top_left;
        pixel_t win_top;
        pixel_t win_top_right;
        pixel_t win_left;
        pixel_t win_center;
        pixel_t win_right;
        pixel_t win_bottom_left;
        pixel_t win_bottom;
        pixel_t win_bottom_right;
        logic   frame_done;
    } out_item_t;

    // per-item control from the front to the back
    typedef struct packed {
        logic emit;
        logic top_pad;
        logic bot_pad;
        logic left_pad;
        logic right_pad;
        logic last;
    } swg_ctl_t;

endpackage

// ----- sv/swg_queue.sv -----
// Small synchronous FIFO used between front and back and on the result side.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module swg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    store_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == CNT_BITS'(DEPTH);
    assign empty   = count_reg == '0;
    assign count   = count_reg;
    assign rd_data = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

endmodule

// ----- sv/swg_front.sv -----
// Front end: accepts items, tracks input and centre positions, classifies each item.
// Depends on swg_pkg.
module swg_front
    import swg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  in_item_t                     in_item,
    input  logic                         mid_full,
    input  logic [CFG_BITS-1:0]          eff_width,
    input  logic [CFG_BITS-1:0]          eff_height,
    input  pixel_t                       pad_pixel,
    input  logic                         restart,
    output logic                         mid_push,
    output pixel_t                       mid_pix,
    output logic [$clog2(MAX_WIDTH)-1:0] mid_col,
    output swg_ctl_t                     mid_ctl
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int CW       = ((COL_BITS > CFG_BITS) ? COL_BITS : CFG_BITS) + 1;
    localparam int RW       = CFG_BITS + 1;

    logic [COL_BITS-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0]       in_row_reg,  in_row_next;
    logic [CW-1:0]       lead_reg,    lead_next;
    logic [COL_BITS-1:0] ctr_col_reg, ctr_col_next;
    logic [CFG_BITS-1:0] ctr_row_reg, ctr_row_next;

    logic          ghost;
    logic          step;
    logic [CW-1:0] w_ext;
    logic [CW-1:0] col_p1;
    logic [CW-1:0] ctr_col_p1;
    logic [RW-1:0] ctr_row_p1;
    swg_ctl_t      ctl;

    always_comb
    begin
        w_ext      = CW'(eff_width);
        col_p1     = CW'(in_col_reg) + CW'(1);
        ctr_col_p1 = CW'(ctr_col_reg) + CW'(1);
        ctr_row_p1 = RW'(ctr_row_reg) + RW'(1);
        // past the last row every item, flush item or not, carries padding
        ghost      = in_row_reg >= RW'(eff_height);
        step       = push && !mid_full && !(in_item.is_drain && !ghost);

        ctl.emit      = lead_reg == w_ext + CW'(1);
        ctl.top_pad   = ctr_row_reg == '0;
        ctl.bot_pad   = ctr_row_p1 >= RW'(eff_height);
        ctl.left_pad  = ctr_col_reg == '0;
        ctl.right_pad = ctr_col_p1 >= w_ext;
        ctl.last      = ctl.bot_pad && ctl.right_pad;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        lead_next    = lead_reg;
        ctr_col_next = ctr_col_reg;
        ctr_row_next = ctr_row_reg;

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            lead_next    = '0;
            ctr_col_next = '0;
            ctr_row_next = '0;
        end
        else if (step)
        begin
            if (col_p1 >= w_ext)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = col_p1[COL_BITS-1:0];
            end
            if (ctl.emit)
            begin
                // hold the lead: input and centre advance together
                if (ctl.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    lead_next    = '0;
                    ctr_col_next = '0;
                    ctr_row_next = '0;
                end
                else if (ctl.right_pad)
                begin
                    ctr_col_next = '0;
                    ctr_row_next = ctr_row_p1[CFG_BITS-1:0];
                end
                else
                begin
                    ctr_col_next = ctr_col_p1[COL_BITS-1:0];
                end
            end
            else
            begin
                lead_next = lead_reg + CW'(1);
            end
        end
    end

    assign mid_push = step;
    assign mid_pix  = ghost ? pad_pixel : in_item.pixel_in;
    assign mid_col  = in_col_reg;
    assign mid_ctl  = ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            lead_reg    <= '0;
            ctr_col_reg <= '0;
            ctr_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            lead_reg    <= lead_next;
            ctr_col_reg <= ctr_col_next;
            ctr_row_reg <= ctr_row_next;
        end
    end

endmodule

// ----- sv/swg_back.sv -----
// Back end: line stores, 3x3 window shift, border padding and the result queue.
// Depends on swg_pkg and swg_queue.
module swg_back
    import swg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mid_empty,
    output logic                         mid_pop,
    input  pixel_t                       mid_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0] mid_col,
    input  swg_ctl_t                     mid_ctl,
    input  pixel_t                       pad_pixel,
    input  logic                         pop,
    output logic                         empty,
    output out_item_t                    out_item
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

    pixel_t upper_mem [MAX_WIDTH];
    pixel_t lower_mem [MAX_WIDTH];

    logic                s_valid_reg;
    pixel_t              s_pix_reg;
    logic [COL_BITS-1:0] s_col_reg;
    swg_ctl_t            s_ctl_reg;
    pixel_t              up_reg;
    pixel_t              lo_reg;
    pixel_t              win_reg  [KERNEL_SIZE][KERNEL_SIZE];
    pixel_t              win_next [KERNEL_SIZE][KERNEL_SIZE];
    pixel_t              sel      [KERNEL_SIZE][KERNEL_SIZE];

    logic [CNT_BITS-1:0] out_count;
    logic                out_full;
    logic                issue;
    logic                fwd;
    logic                res_push;
    out_item_t           res_item;
    logic                row_out;
    logic                col_out;

    // one item in flight at most, so keep a free slot for it
    assign issue   = !mid_empty &&
                     ((CNT_BITS + 1)'(out_count) + (CNT_BITS + 1)'(s_valid_reg)
                      < (CNT_BITS + 1)'(OUT_DEPTH));
    assign mid_pop = issue;
    // same column written back at this edge: take the new values
    assign fwd     = s_valid_reg && (s_col_reg == mid_col);

    always_ff @(posedge clk)
    begin
        if (s_valid_reg)
        begin
            upper_mem[s_col_reg] <= lo_reg;
            lower_mem[s_col_reg] <= s_pix_reg;
        end
        if (issue)
        begin
            if (fwd)
            begin
                up_reg <= lo_reg;
                lo_reg <= s_pix_reg;
            end
            else
            begin
                up_reg <= upper_mem[mid_col];
                lo_reg <= lower_mem[mid_col];
            end
            s_pix_reg <= mid_pix;
            s_col_reg <= mid_col;
            s_ctl_reg <= mid_ctl;
        end
    end

    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++)
            begin
                win_next[r][c] = win_reg[r][c+1];
            end
        end
        win_next[0][KERNEL_SIZE-1] = up_reg;
        win_next[1][KERNEL_SIZE-1] = lo_reg;
        win_next[2][KERNEL_SIZE-1] = s_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            for (int r = 0; r < KERNEL_SIZE; r++)
            begin
                for (int c = 0; c < KERNEL_SIZE; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            s_valid_reg <= issue;
            if (s_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                row_out = (r == 0 && s_ctl_reg.top_pad) ||
                          (r == KERNEL_SIZE - 1 && s_ctl_reg.bot_pad);
                col_out = (c == 0 && s_ctl_reg.left_pad) ||
                          (c == KERNEL_SIZE - 1 && s_ctl_reg.right_pad);
                sel[r][c] = (row_out || col_out) ? pad_pixel : win_next[r][c];
            end
        end
        res_item.win_top_left     = sel[0][0];
        res_item.win_top          = sel[0][1];
        res_item.win_top_right    = sel[0][2];
        res_item.win_left         = sel[1][0];
        res_item.win_center       = sel[1][1];
        res_item.win_right        = sel[1][2];
        res_item.win_bottom_left  = sel[2][0];
        res_item.win_bottom       = sel[2][1];
        res_item.win_bottom_right = sel[2][2];
        res_item.frame_done       = s_ctl_reg.last;
    end

    assign res_push = s_valid_reg && s_ctl_reg.emit;

    swg_queue #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_item),
        .pop     (pop),
        .rd_data (out_item),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    // credit check above keeps the queue from overflowing
    logic unused_full;
    assign unused_full = out_full;

endmodule

// ----- sv/sliding_window_generator.sv -----
// Top level of the 3x3 sliding window generator: registers, front, queue, back.
// Depends on swg_pkg, swg_queue, swg_front and swg_back.
//
// Usage: pixels of a frame enter in raster order on in_item while push is high
// and full is low. Every accepted pixel or flush item may produce one 3x3
// window; the window of a centre pixel appears once its lower-right neighbour
// has been accepted, so frame_width + 1 flush items (is_drain = 1) after the
// last pixel drain the frame. Drain items before the frame is complete are
// accepted and dropped. frame_done marks the window of the last centre.
// Results sit on out_item while empty is low and leave when pop is high.
// Throughput is one item per clock while full is low; the front accepts into a
// two-deep queue, the back reads both line stores (one synchronous read each)
// and pushes into a four-deep result queue. A window reaches out_item through
// the middle queue, the read stage and the result queue. When pop is held low
// the result queue fills, the back stops and then full rises; nothing is lost.
// Reset clears positions, window and queues; width 640, height 480, pad 0.
// Line store contents are not cleared. Writing frame_width or frame_height
// restarts the frame; write registers only while the block is idle.
module sliding_window_generator
    import swg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  in_item_t            in_item,
    output logic                empty,
    input  logic                pop,
    output out_item_t           out_item,
    input  logic                wr_en,
    input  logic [IDX_BITS-1:0] wr_index,
    input  pixel_t              wr_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int MID_BITS = PIXEL_BITS + COL_BITS + $bits(swg_ctl_t);

    logic [CFG_BITS-1:0] frame_width_reg;
    logic [CFG_BITS-1:0] frame_height_reg;
    pixel_t              pad_pixel_reg;
    logic [CFG_BITS-1:0] eff_width;
    logic [CFG_BITS-1:0] eff_height;
    logic                restart;

    logic                mid_push;
    logic                mid_pop;
    logic                mid_full;
    logic                mid_empty;
    pixel_t              f_pix;
    logic [COL_BITS-1:0] f_col;
    swg_ctl_t            f_ctl;
    pixel_t              b_pix;
    logic [COL_BITS-1:0] b_col;
    swg_ctl_t            b_ctl;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            pad_pixel_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= wr_data[CFG_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= wr_data[CFG_BITS-1:0];
                REG_PAD_PIXEL:    pad_pixel_reg    <= wr_data;
                default:          ;
            endcase
        end
    end

    assign restart = wr_en &&
                     (wr_index == REG_FRAME_WIDTH || wr_index == REG_FRAME_HEIGHT);

    // clamp geometry: zero reads as one, width limited to the line store depth
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_width = CFG_BITS'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_width = CFG_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_width = frame_width_reg;
        end
        eff_height = (frame_height_reg == '0) ? CFG_BITS'(1) : frame_height_reg;
    end

    swg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_item    (in_item),
        .mid_full   (mid_full),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .pad_pixel  (pad_pixel_reg),
        .restart    (restart),
        .mid_push   (mid_push),
        .mid_pix    (f_pix),
        .mid_col    (f_col),
        .mid_ctl    (f_ctl)
    );

    assign full = mid_full;

    swg_queue #(
        .WIDTH (MID_BITS),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data ({f_pix, f_col, f_ctl}),
        .pop     (mid_pop),
        .rd_data ({b_pix, b_col, b_ctl}),
        .full    (mid_full),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    swg_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_pix   (b_pix),
        .mid_col   (b_col),
        .mid_ctl   (b_ctl),
        .pad_pixel (pad_pixel_reg),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

    // fill level of the middle queue is not needed here
    logic unused_mid_count;
    assign unused_mid_count = ^mid_count;

endmodule
